// File: hdl/vmd_pkg.sv
// Shared types and constants of the value match dilation block.
// No dependencies; used by vmd_line_store and value_match_dilation_3x3_top.
package vmd_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int DIM_W      = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_SLOTS  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_lane;

    localparam t_cfg_idx CFG_FRAME_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_FRAME_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_MATCH_VALUE  = 2'd2;

    localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 12'd64;
    localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 12'd64;
    localparam logic [SAMPLE_W-1:0] RST_MATCH_VALUE  = 10'd1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic  top_ok;
        logic  bot_ok;
        logic  left_ok;
        logic  right_ok;
        logic  first;
        logic  last;
        t_lane lane_top;
        t_lane lane_mid;
    } t_step;

endpackage

// File: hdl/vmd_line_store.sv
// Line store: one word per column holding that column's sample of four rows.
// Lane-wise write, registered read. Depends on vmd_pkg.
module vmd_line_store #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 10
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]                      i_wr_addr,
    input  vmd_pkg::t_lane                                i_wr_lane,
    input  logic [DATA_W-1:0]                             i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]                      i_rd_addr,
    output logic [vmd_pkg::ROW_SLOTS-1:0][DATA_W-1:0]     o_rd_data
);

    logic [vmd_pkg::ROW_SLOTS-1:0][DATA_W-1:0] r_mem [DEPTH];
    logic [vmd_pkg::ROW_SLOTS-1:0][DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][i_wr_lane] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/value_match_dilation_3x3_top.sv
// Top level of the 3x3 value match dilation block.
// Depends on vmd_pkg and vmd_line_store.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one word per accepted cycle, either a
//   pixel sample in raster order or a drain tick. Output channel (o_out_valid /
//   i_out_stall): one dilated sample per word, o_out_last on the frame's last one.
//   Output number q is caused by input number q + width + 1; after the last pixel,
//   one drain tick (or extra pixel, whose sample is dropped) per remaining output.
//   Drain ticks with nothing pending produce no output.
//   Throughput: one word per cycle while the output is not stalled, set by the
//   single line store access per word (one column read, one lane write). Stall:
//   a stalled output holds; the one-deep read stage keeps accepting until it is
//   full, then o_in_stall rises in the same cycle as i_out_stall. Reset: counters
//   clear, registers return to width 64, height 64, match 1; the line store needs
//   no clearing pass. Writing width or height restarts the frame. Configuration is
//   written through i_cfg_we / i_cfg_index / i_cfg_data while idle, a rule
//   for the user that the block itself does not enforce.
module value_match_dilation_3x3_top #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  vmd_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [vmd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [vmd_pkg::SAMPLE_W-1:0]      i_in_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [vmd_pkg::SAMPLE_W-1:0]      o_out_sample,
    output logic                              o_out_last
);

    localparam int OW     = vmd_pkg::SAMPLE_W;
    localparam int DW     = vmd_pkg::DIM_W;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = ($clog2(MAX_HEIGHT + 1) > 2) ? $clog2(MAX_HEIGHT + 1) : 2;
    localparam int SW     = (SAMPLE_BITS < OW) ? SAMPLE_BITS : OW;
    localparam int WCALC  = ($clog2(MAX_WIDTH + 1) > DW) ? $clog2(MAX_WIDTH + 1) : DW;
    localparam int HCALC  = ($clog2(MAX_HEIGHT + 1) > DW) ? $clog2(MAX_HEIGHT + 1) : DW;

    // configuration
    logic [DW-1:0] r_frame_width;
    logic [DW-1:0] r_frame_height;
    logic [OW-1:0] r_match_value;

    // positions
    logic [CW-1:0] r_ic, n_ic;
    logic [RW-1:0] r_ir, n_ir;
    logic [CW-1:0] r_oc, n_oc;
    logic [RW-1:0] r_or, n_or;

    // first column samples for the first output
    logic [SW-1:0] r_s00;
    logic [SW-1:0] r_s10;

    // read stage
    logic           r_va;
    vmd_pkg::t_step r_a_step;
    logic [SW-1:0]  r_a_bot;

    // window history: [row]
    logic [SW-1:0] r_hl [3];
    logic [SW-1:0] r_hc [3];

    // output register
    logic          r_vo;
    logic [OW-1:0] r_out_sample;
    logic          r_out_last;

    logic [WCALC-1:0] fw_ext;
    logic [HCALC-1:0] fh_ext;
    logic [CW-1:0]    w_m1;
    logic [RW-1:0]    h_m1;
    logic [SW-1:0]    mv;

    logic           in_done;
    logic           is_pix;
    logic           past_lead;
    logic           emit;
    logic           accept;
    logic           step_go;
    logic           pix_go;
    logic           adv;
    logic           o_last_col;
    logic           o_last_row;
    vmd_pkg::t_lane nxt_row_lsb;
    logic [CW-1:0]  rd_col;
    vmd_pkg::t_step step;
    logic           geom_wr;

    logic [vmd_pkg::ROW_SLOTS-1:0][SW-1:0] rd_word;

    logic [SW-1:0] win [3][3];
    logic          win_ok [3][3];
    logic          hit;
    logic [SW-1:0] b_result;

    // effective geometry
    assign fw_ext = WCALC'(r_frame_width);
    assign fh_ext = HCALC'(r_frame_height);

    always_comb begin
        if (fw_ext == '0) begin
            w_m1 = '0;
        end else if (fw_ext > WCALC'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(fw_ext - WCALC'(1));
        end
        if (fh_ext == '0) begin
            h_m1 = '0;
        end else if (fh_ext > HCALC'(MAX_HEIGHT)) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(fh_ext - HCALC'(1));
        end
    end

    assign mv = r_match_value[SW-1:0];

    // issue control
    assign in_done   = r_ir > h_m1;
    assign is_pix    = !in_done && (i_req_type == vmd_pkg::REQ_PIXEL);
    assign past_lead = (r_ir > RW'(1)) || ((r_ir == RW'(1)) && (r_ic != '0));
    assign emit      = is_pix ? past_lead : in_done;

    assign adv        = r_va && (!r_vo || !i_out_stall);
    assign o_in_stall = r_va && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign step_go    = accept && emit;
    assign pix_go     = accept && is_pix;

    assign o_last_col  = r_oc == w_m1;
    assign o_last_row  = r_or == h_m1;
    assign nxt_row_lsb = o_last_col ? vmd_pkg::t_lane'(r_or[1:0] + 2'd1) : r_or[1:0];
    assign rd_col      = o_last_col ? '0 : CW'(r_oc + CW'(1));

    always_comb begin
        step.top_ok   = r_or != '0;
        step.bot_ok   = !o_last_row;
        step.left_ok  = r_oc != '0;
        step.right_ok = !o_last_col;
        step.first    = (r_or == '0) && (r_oc == '0);
        step.last     = o_last_row && o_last_col;
        step.lane_top = vmd_pkg::t_lane'(nxt_row_lsb - 2'd1);
        step.lane_mid = nxt_row_lsb;
    end

    assign geom_wr = i_cfg_we && (i_cfg_index inside {vmd_pkg::CFG_FRAME_WIDTH,
                                                      vmd_pkg::CFG_FRAME_HEIGHT});

    always_comb begin
        n_ic = r_ic;
        n_ir = r_ir;
        n_oc = r_oc;
        n_or = r_or;
        if (pix_go) begin
            if (r_ic == w_m1) begin
                n_ic = '0;
                n_ir = RW'(r_ir + RW'(1));
            end else begin
                n_ic = CW'(r_ic + CW'(1));
            end
        end
        if (step_go) begin
            if (o_last_col) begin
                n_oc = '0;
                n_or = RW'(r_or + RW'(1));
            end else begin
                n_oc = CW'(r_oc + CW'(1));
            end
        end
        if ((step_go && step.last) || geom_wr) begin
            n_ic = '0;
            n_ir = '0;
            n_oc = '0;
            n_or = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= vmd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= vmd_pkg::RST_FRAME_HEIGHT;
            r_match_value  <= vmd_pkg::RST_MATCH_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vmd_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                vmd_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                vmd_pkg::CFG_MATCH_VALUE:  r_match_value  <= i_cfg_data[OW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= '0;
            r_ir <= '0;
            r_oc <= '0;
            r_or <= '0;
        end else begin
            r_ic <= n_ic;
            r_ir <= n_ir;
            r_oc <= n_oc;
            r_or <= n_or;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go && (r_ir == '0) && (r_ic == '0)) begin
            r_s00 <= i_in_sample[SW-1:0];
        end
        if (pix_go && (r_ir == RW'(1)) && (r_ic == '0)) begin
            r_s10 <= i_in_sample[SW-1:0];
        end
    end

    vmd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (SW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (pix_go),
        .i_wr_addr (r_ic),
        .i_wr_lane (r_ir[1:0]),
        .i_wr_data (i_in_sample[SW-1:0]),
        .i_rd_en   (step_go),
        .i_rd_addr (rd_col),
        .o_rd_data (rd_word)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (step_go) begin
            r_va <= 1'b1;
        end else if (adv) begin
            r_va <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_a_step <= step;
            r_a_bot  <= i_in_sample[SW-1:0];
        end
    end

    // window and match
    always_comb begin
        win[0][0] = r_hl[0];
        win[0][1] = r_hl[1];
        win[0][2] = r_hl[2];
        win[1][0] = r_hc[0];
        win[1][1] = r_a_step.first ? r_s00 : r_hc[1];
        win[1][2] = r_a_step.first ? r_s10 : r_hc[2];
        win[2][0] = rd_word[r_a_step.lane_top];
        win[2][1] = rd_word[r_a_step.lane_mid];
        win[2][2] = r_a_bot;
        for (int c = 0; c < 3; c++) begin
            win_ok[c][0] = r_a_step.top_ok;
            win_ok[c][1] = 1'b1;
            win_ok[c][2] = r_a_step.bot_ok;
        end
        for (int r = 0; r < 3; r++) begin
            win_ok[0][r] = win_ok[0][r] && r_a_step.left_ok;
            win_ok[2][r] = win_ok[2][r] && r_a_step.right_ok;
        end
        hit = 1'b0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (win_ok[c][r] && (win[c][r] == mv)) begin
                    hit = 1'b1;
                end
            end
        end
        b_result = hit ? mv : win[1][1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_hl[r] <= win[1][r];
                r_hc[r] <= win[2][r];
            end
            r_out_sample <= OW'(b_result);
            r_out_last   <= r_a_step.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vo <= 1'b1;
        end else if (!i_out_stall) begin
            r_vo <= 1'b0;
        end
    end

    assign o_out_valid  = r_vo;
    assign o_out_sample = r_out_sample;
    assign o_out_last   = r_out_last;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && step.last) |=> ((r_ic == '0) && (r_ir == '0) &&
                                    (r_oc == '0) && (r_or == '0)))
        else $error("position counters not cleared after frame end");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> ((r_oc <= w_m1) && (r_or <= h_m1) && (r_ic <= w_m1)))
        else $error("raster position outside frame");

    a_pix_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && is_pix) |-> ((r_ic == rd_col) &&
                                 (r_ir[1:0] == vmd_pkg::t_lane'(nxt_row_lsb + 2'd1))))
        else $error("input word out of step with window column");

endmodule
